>>> rtl/nps_pkg.sv
// ============================================================================
// nps_pkg: shared types and constants for the priority scheduler
// Holds the sequencer state type, field widths and the job record layout.
// ============================================================================
package nps_pkg;

    localparam int BURST_W = 16;
    localparam int PRIO_W  = 8;
    localparam int IDX_W   = 5;
    localparam int TIME_W  = 21;
    localparam int TOT_W   = 27;

    // One stored job: priority, burst and original load index.
    typedef struct packed {
        logic [PRIO_W-1:0]  prio;
        logic [BURST_W-1:0] burst;
        logic [IDX_W-1:0]   idx;
    } t_job;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_SEL_RD,
        ST_SEL_CMP,
        ST_SWAP_RD,
        ST_SWAP_WR,
        ST_SUM_RD,
        ST_SUM_ACC,
        ST_DIV,
        ST_OUT_RD,
        ST_OUT_WAIT,
        ST_OUT_SEND
    } t_state;

endpackage

>>> rtl/nps_job_ram.sv
// ============================================================================
// nps_job_ram: job record memory
// Single write port and a registered read port; data comes the next cycle.
// A read of the entry that is written in the same cycle returns the new data.
// ============================================================================
module nps_job_ram
    import nps_pkg::*;
#(
    parameter int DEPTH = 32,
    parameter int AW    = 5
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  t_job          i_wdata,
    input  logic [AW-1:0] i_raddr,
    output t_job          o_rdata
);

    t_job r_mem [DEPTH];
    t_job r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_we && (i_waddr == i_raddr)) begin
            r_rdata <= i_wdata;
        end else begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/nps_divider.sv
// ============================================================================
// nps_divider: restoring divider
// Produces one quotient bit per cycle for an unsigned total over a job count.
// ============================================================================
module nps_divider
    import nps_pkg::*;
#(
    parameter int DW = 7
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [TOT_W-1:0] i_dividend,
    input  logic [DW-1:0]    i_divisor,
    output logic             o_busy,
    output logic [TOT_W-1:0] o_quotient
);

    localparam int CW = $clog2(TOT_W + 1);

    logic [CW-1:0]    r_cnt;
    logic [CW-1:0]    n_cnt;
    logic [TOT_W-1:0] r_quo;
    logic [TOT_W-1:0] n_quo;
    logic [DW:0]      r_rem;
    logic [DW:0]      n_rem;
    logic [DW-1:0]    r_div;
    logic [DW:0]      w_trial;

    assign w_trial = {r_rem[DW-1:0], r_quo[TOT_W-1]};

    always_comb begin
        n_cnt = r_cnt;
        n_quo = r_quo;
        n_rem = r_rem;
        if (i_start) begin
            n_cnt = CW'(TOT_W);
            n_quo = i_dividend;
            n_rem = '0;
        end else if (r_cnt != '0) begin
            n_cnt = r_cnt - 1'b1;
            if (w_trial >= {1'b0, r_div}) begin
                n_rem = w_trial - {1'b0, r_div};
                n_quo = {r_quo[TOT_W-2:0], 1'b1};
            end else begin
                n_rem = w_trial;
                n_quo = {r_quo[TOT_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
        r_quo <= n_quo;
        r_rem <= n_rem;
        if (i_start) begin
            r_div <= i_divisor;
        end
    end

    assign o_busy     = (r_cnt != '0);
    assign o_quotient = r_quo;

endmodule

>>> rtl/nonpreemptive_priority_schedule.sv
// ============================================================================
// nonpreemptive_priority_schedule: non-preemptive priority scheduler
// Loads a batch of jobs, selection-sorts them by priority in a job memory
// and streams out per-job wait and turnaround times with batch averages.
// ============================================================================
//
// Channel  Dir  Fields (lowest bit up)
// s_axis   in   tdata: burst_time[15:0], priority_req[23:16]; tlast: is_last
// m_axis   out  tdata: job_index[4:0], burst_out[20:5], wait_time[41:21],
//               turnaround_time[62:42], avg_wait[83:63],
//               avg_turnaround[104:84]; tlast: last_result
//
// A job is loaded with each accepted input transaction. After the
// transaction with tlast set, the block sorts (each pass reads entry i,
// compares the rest, then reads and swaps the best), sums the times,
// divides both totals by the job count on one shared serial divider,
// and sends each result after reading its entry from the job memory,
// whose single read port sets the pace of each of these steps.
// Reset (synchronous, active low) empties the batch; the memory is not
// cleared. The input is not accepted during sorting, summing, division
// or output; a stalled output holds its result until m_axis_tready.
// ============================================================================
module nonpreemptive_priority_schedule
    import nps_pkg::*;
#(
    parameter int MAX_PROCS = 32
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [23:0]  s_axis_tdata,   // burst_time, priority_req
    input  logic         s_axis_tlast,   // is_last
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [111:0] m_axis_tdata,   // job_index, burst_out, wait_time,
                                         // turnaround_time, avg_wait,
                                         // avg_turnaround
    output logic         m_axis_tlast    // last_result
);

    localparam int AW = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
    localparam int CW = $clog2(MAX_PROCS + 1);

    t_state r_state, n_state;

    logic [CW-1:0]    r_count, n_count;  // jobs held
    logic [CW-1:0]    r_i, n_i;          // sort pass / output position
    logic [CW-1:0]    r_j, n_j;          // scan position
    logic [CW-1:0]    r_best, n_best;
    logic [PRIO_W-1:0] r_best_prio, n_best_prio;
    t_job             r_hold, n_hold;    // entry i during swap
    logic [TOT_W-1:0] r_acc, n_acc;
    logic [TOT_W-1:0] r_wtot, n_wtot;
    logic [TOT_W-1:0] r_ttot, n_ttot;
    logic [TOT_W-1:0] r_avg_w, n_avg_w;
    logic             r_div_sel, n_div_sel;
    logic [TIME_W-1:0] r_o_wait, n_o_wait;
    logic             r_div_go;

    // Memory ports
    logic     w_we;
    logic [AW-1:0] w_waddr, w_raddr;
    t_job     w_wdata, w_rdata;

    // The swap write of entry best needs a second write; done with a
    // dedicated register stage below.
    logic       r_wb_pend;
    logic [AW-1:0] r_wb_addr;
    t_job       r_wb_data;
    logic     w_we2;
    t_job     w_mem_wdata;
    logic [AW-1:0] w_mem_waddr;
    logic     w_mem_we;

    // Divider
    logic             w_div_start;
    logic             w_div_busy;
    logic [TOT_W-1:0] w_quo;

    logic w_in_acc, w_out_acc;
    assign w_in_acc  = s_axis_tvalid && s_axis_tready;
    assign w_out_acc = m_axis_tvalid && m_axis_tready;

    nps_job_ram #(.DEPTH(MAX_PROCS), .AW(AW)) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_waddr (w_mem_waddr),
        .i_wdata (w_mem_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    nps_divider #(.DW(CW)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (r_div_sel ? r_ttot : r_wtot),
        .i_divisor  (r_count),
        .o_busy     (w_div_busy),
        .o_quotient (w_quo)
    );

    // Next-state logic
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_LOAD: begin
                if (w_in_acc && s_axis_tlast) begin
                    n_state = ST_SEL_RD;
                end
            end
            ST_SEL_RD: begin
                if (r_i == r_count) begin
                    n_state = ST_SUM_RD;
                end else begin
                    n_state = ST_SEL_CMP;
                end
            end
            ST_SEL_CMP: begin
                if (r_j + 1'b1 == r_count) begin
                    n_state = ST_SWAP_RD;
                end else begin
                    n_state = ST_SEL_CMP;
                end
            end
            ST_SWAP_RD: n_state = ST_SWAP_WR;
            ST_SWAP_WR: n_state = ST_SEL_RD;
            ST_SUM_RD: begin
                if (r_i == r_count) begin
                    n_state = ST_DIV;
                end else begin
                    n_state = ST_SUM_ACC;
                end
            end
            ST_SUM_ACC: n_state = ST_SUM_RD;
            ST_DIV: begin
                if (!r_div_go && !w_div_busy && r_div_sel) begin
                    n_state = ST_OUT_RD;
                end
            end
            ST_OUT_RD: n_state = ST_OUT_WAIT;
            ST_OUT_WAIT: n_state = ST_OUT_SEND;
            ST_OUT_SEND: begin
                if (w_out_acc) begin
                    if (r_i + 1'b1 == r_count) begin
                        n_state = ST_LOAD;
                    end else begin
                        n_state = ST_OUT_RD;
                    end
                end
            end
            default: n_state = ST_LOAD;
        endcase
    end

    // Datapath and output logic
    always_comb begin
        n_count     = r_count;
        n_i         = r_i;
        n_j         = r_j;
        n_best      = r_best;
        n_best_prio = r_best_prio;
        n_hold      = r_hold;
        n_acc       = r_acc;
        n_wtot      = r_wtot;
        n_ttot      = r_ttot;
        n_avg_w     = r_avg_w;
        n_div_sel   = r_div_sel;
        n_o_wait    = r_o_wait;
        w_we        = 1'b0;
        w_waddr     = r_count[AW-1:0];
        w_wdata     = w_rdata;
        w_raddr     = r_i[AW-1:0];
        w_div_start = 1'b0;
        s_axis_tready = 1'b0;
        m_axis_tvalid = 1'b0;
        case (r_state)
            ST_LOAD: begin
                s_axis_tready = 1'b1;
                w_wdata.prio  = s_axis_tdata[23:16];
                w_wdata.burst = s_axis_tdata[15:0];
                w_wdata.idx   = IDX_W'(r_count);
                if (w_in_acc && (r_count < CW'(MAX_PROCS))) begin
                    w_we    = 1'b1;
                    n_count = r_count + 1'b1;
                end
                n_i = '0;
            end
            ST_SEL_RD: begin
                // Read entry i; scan starts at i
                w_raddr = r_i[AW-1:0];
                n_j     = r_i;
                n_best  = r_i;
                if (r_i == r_count) begin
                    n_i    = '0;
                    n_acc  = '0;
                    n_wtot = '0;
                    n_ttot = '0;
                end
            end
            ST_SEL_CMP: begin
                // w_rdata is entry r_j; issue read of r_j+1
                w_raddr = AW'(r_j + 1'b1);
                if (r_j == r_i) begin
                    n_best_prio = w_rdata.prio;
                    n_hold      = w_rdata;
                end else if (w_rdata.prio < r_best_prio) begin
                    n_best_prio = w_rdata.prio;
                    n_best      = r_j;
                end
                n_j = r_j + 1'b1;
            end
            ST_SWAP_RD: begin
                // Every scan entry was compared in ST_SEL_CMP, so r_j equals
                // r_count here and no compare is made. The final best is read here.
                if (r_j != r_count && w_rdata.prio < r_best_prio) begin
                    n_best = r_j;
                end
                w_raddr = n_best[AW-1:0];
            end
            ST_SWAP_WR: begin
                // rdata is entry best, read in SWAP_RD
                w_we    = 1'b1;
                w_waddr = r_i[AW-1:0];
                w_wdata = w_rdata;
                n_i     = r_i + 1'b1;
            end
            ST_SUM_RD: begin
                w_raddr = r_i[AW-1:0];
            end
            ST_SUM_ACC: begin
                n_wtot = r_wtot + r_acc;
                n_ttot = r_ttot + r_acc + TOT_W'(w_rdata.burst);
                n_acc  = r_acc + TOT_W'(w_rdata.burst);
                n_i    = r_i + 1'b1;
                n_div_sel = 1'b0;
            end
            ST_DIV: begin
                w_div_start = r_div_go;
                if (!r_div_go && !w_div_busy) begin
                    if (!r_div_sel) begin
                        n_avg_w   = w_quo;
                        n_div_sel = 1'b1;
                    end else begin
                        n_i   = '0;
                        n_acc = '0;
                    end
                end
            end
            ST_OUT_RD: begin
                w_raddr = r_i[AW-1:0];
            end
            ST_OUT_WAIT: begin
                w_raddr = r_i[AW-1:0];
                n_o_wait = r_acc[TIME_W-1:0];
            end
            ST_OUT_SEND: begin
                w_raddr = r_i[AW-1:0];
                m_axis_tvalid = 1'b1;
                if (w_out_acc) begin
                    n_acc = r_acc + TOT_W'(w_rdata.burst);
                    n_i   = r_i + 1'b1;
                    if (r_i + 1'b1 == r_count) begin
                        n_count = '0;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_LOAD;
            r_count   <= '0;
            r_i       <= '0;
            r_div_go  <= 1'b0;
            r_div_sel <= 1'b0;
            r_wb_pend <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_i       <= n_i;
            r_div_sel <= n_div_sel;
            // Start a division on entry to ST_DIV and once more after the first
            r_div_go  <= ((r_state == ST_SUM_RD) && (r_i == r_count))
                       || ((r_state == ST_DIV) && !r_div_go && !w_div_busy
                           && !r_div_sel);
            r_wb_pend <= (r_state == ST_SWAP_WR);
        end
        r_j         <= n_j;
        r_best      <= n_best;
        r_best_prio <= n_best_prio;
        r_hold      <= n_hold;
        r_acc       <= n_acc;
        r_wtot      <= n_wtot;
        r_ttot      <= n_ttot;
        r_avg_w     <= n_avg_w;
        r_o_wait    <= n_o_wait;
        r_wb_addr   <= r_best[AW-1:0];
        r_wb_data   <= r_hold;
    end

    // Second swap write: old entry i goes to best. ST_SEL_RD follows
    // ST_SWAP_WR and does not write, so this port use is free there. Its
    // read of the next entry i sees this write through the memory's
    // write-first read port.
    assign w_we2 = r_wb_pend;

    assign w_mem_we    = w_we || w_we2;
    assign w_mem_waddr = w_we2 ? r_wb_addr : w_waddr;
    assign w_mem_wdata = w_we2 ? r_wb_data : w_wdata;

    // Output payload
    logic [TIME_W-1:0] w_burst21;
    assign w_burst21 = TIME_W'(w_rdata.burst);
    assign m_axis_tdata = {7'd0,
                           w_quo[TIME_W-1:0],
                           r_avg_w[TIME_W-1:0],
                           r_o_wait + w_burst21,
                           r_o_wait,
                           w_rdata.burst,
                           w_rdata.idx};
    assign m_axis_tlast = (r_i + 1'b1 == r_count);

`ifndef ASSERT_OFF
    a_no_in_when_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_LOAD) |-> !s_axis_tready)
        else $error("input accepted outside loading");
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_PROCS))
        else $error("job count above capacity");
    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_acc && m_axis_tlast) |=> (r_state == ST_LOAD) && (r_count == '0))
        else $error("batch not closed after last result");
`endif

endmodule
